// ===== sv/ljjt_pkg.sv =====
// Shared types, constants and the microprogram of the leg Jacobian and torque block.
`default_nettype none
package ljjt_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_HIP_LENGTH   = 3'd0;
    localparam logic [2:0] CFG_THIGH_LENGTH = 3'd1;
    localparam logic [2:0] CFG_CALF_LENGTH  = 3'd2;
    localparam logic [2:0] CFG_CALF_OFFSET  = 3'd3;
    localparam logic [2:0] CFG_LEG_SIDE     = 3'd4;

    localparam logic OP_ANGLES = 1'b0;
    localparam logic OP_FORCE  = 1'b1;

    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_TORQUE = 1'b1;

    localparam int NW = 37;   // width of the angle reduction word
    localparam logic signed [NW-1:0] HALF_PI_Q30 = NW'(64'sd1686629713);
    localparam logic signed [NW-1:0] QTR_PI_Q30  = NW'(64'sd843314856);
    localparam logic signed [31:0]   Q30_ONE     = 32'sd1073741824;

    localparam logic [31:0] RECIP_72 = 32'((64'd1 << 32) / 72);
    localparam logic [31:0] RECIP_42 = 32'((64'd1 << 32) / 42);
    localparam logic [31:0] RECIP_20 = 32'((64'd1 << 32) / 20);
    localparam logic [31:0] RECIP_6  = 32'((64'd1 << 32) / 6);
    localparam logic [31:0] RECIP_90 = 32'((64'd1 << 32) / 90);
    localparam logic [31:0] RECIP_56 = 32'((64'd1 << 32) / 56);
    localparam logic [31:0] RECIP_30 = 32'((64'd1 << 32) / 30);
    localparam logic [31:0] RECIP_12 = 32'((64'd1 << 32) / 12);

    localparam logic [7:0] PC_TRIG  = 8'd0;
    localparam logic [7:0] PC_JAC   = 8'd40;
    localparam logic [7:0] PC_FORCE = 8'd116;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } ljjt_state_t;

    typedef enum logic [3:0] {
        UOP_ANG,   // load angle of the current trig pass
        UOP_RED,   // one quadrant reduction step, wait until reduced
        UOP_MUL,   // product register <= a * b
        UOP_M30,   // dst <= product rounded by 2^30
        UOP_DIVF,  // dst <= one - a / divisor, product holds a * reciprocal
        UOP_HALF,  // dst <= one - a / 2
        UOP_QSIN,  // sine of current pass after quadrant map
        UOP_QCOS,  // cosine of current pass after quadrant map
        UOP_AADD,
        UOP_ASUB,
        UOP_ACCL,  // hip term, negative on a left leg
        UOP_ACCR,  // hip term, negative on a right leg
        UOP_Q20,   // dst <= accumulator rounded to Q.20, clear accumulator
        UOP_TRQ,   // dst <= accumulator rounded to Q.8 and saturated, clear
        UOP_LOOP,  // next trig pass or fall through
        UOP_END
    } uop_t;

    typedef enum logic [4:0] {
        OPD_X, OPD_X2, OPD_T, OPD_V,
        OPD_LH, OPD_LT, OPD_LC,
        OPD_SN0, OPD_SN1, OPD_SN2, OPD_SN3,
        OPD_CN0, OPD_CN1, OPD_CN2, OPD_CN3,
        OPD_J0, OPD_J1, OPD_J2, OPD_J3, OPD_J4, OPD_J5, OPD_J6, OPD_J7, OPD_J8,
        OPD_FX, OPD_FY, OPD_FZ,
        OPD_RECIP
    } opd_t;

    typedef enum logic [4:0] {
        DST_NONE, DST_X2, DST_T, DST_V, DST_S, DST_C, DST_SN, DST_CN,
        DST_J0, DST_J1, DST_J2, DST_J3, DST_J4, DST_J5, DST_J6, DST_J7, DST_J8,
        DST_TQ0, DST_TQ1, DST_TQ2
    } dst_t;

    typedef enum logic [2:0] {
        DIV_72, DIV_42, DIV_20, DIV_6, DIV_90, DIV_56, DIV_30, DIV_12
    } divc_t;

    typedef struct packed {
        uop_t  op;
        opd_t  a;
        opd_t  b;
        dst_t  dst;
        divc_t dv;
    } uword_t;

    typedef struct packed {
        logic       run;
        logic       load;
        uword_t     uw;
        logic [1:0] ti;
        logic [1:0] row;
        logic       kind;
    } ljjt_cmd_t;

    typedef struct packed {
        logic reduced;
    } ljjt_stat_t;

    function automatic logic [6:0] div_value(input divc_t d);
        logic [6:0] v;
        unique case (d)
            DIV_72:  v = 7'd72;
            DIV_42:  v = 7'd42;
            DIV_20:  v = 7'd20;
            DIV_6:   v = 7'd6;
            DIV_90:  v = 7'd90;
            DIV_56:  v = 7'd56;
            DIV_30:  v = 7'd30;
            DIV_12:  v = 7'd12;
            default: v = 7'd72;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] div_recip(input divc_t d);
        logic [31:0] v;
        unique case (d)
            DIV_72:  v = RECIP_72;
            DIV_42:  v = RECIP_42;
            DIV_20:  v = RECIP_20;
            DIV_6:   v = RECIP_6;
            DIV_90:  v = RECIP_90;
            DIV_56:  v = RECIP_56;
            DIV_30:  v = RECIP_30;
            DIV_12:  v = RECIP_12;
            default: v = RECIP_72;
        endcase
        return v;
    endfunction

    function automatic uword_t mk(input uop_t op, input opd_t a, input opd_t b,
                                  input dst_t dst, input divc_t dv);
        uword_t u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.dst = dst;
        u.dv  = dv;
        return u;
    endfunction

    function automatic uword_t uw_mul(input opd_t a, input opd_t b);
        return mk(UOP_MUL, a, b, DST_NONE, DIV_72);
    endfunction

    function automatic uword_t uw_op(input uop_t op, input dst_t dst);
        return mk(op, OPD_X, OPD_X, dst, DIV_72);
    endfunction

    function automatic uword_t uw_div(input opd_t a, input dst_t dst, input divc_t dv);
        return mk(UOP_DIVF, a, OPD_X, dst, dv);
    endfunction

    function automatic uword_t uw_recip(input opd_t a, input divc_t dv);
        return mk(UOP_MUL, a, OPD_RECIP, DST_NONE, dv);
    endfunction

    // microprogram: trig pass, Jacobian, torques
    function automatic uword_t ucode(input logic [7:0] pc);
        uword_t u;
        unique case (pc)
            // trig pass over one angle
            8'd0:   u = uw_op(UOP_ANG, DST_NONE);
            8'd1:   u = uw_op(UOP_RED, DST_NONE);
            8'd2:   u = uw_mul(OPD_X, OPD_X);
            8'd3:   u = uw_op(UOP_M30, DST_X2);
            8'd4:   u = uw_recip(OPD_X2, DIV_72);
            8'd5:   u = uw_div(OPD_X2, DST_T, DIV_72);
            8'd6:   u = uw_mul(OPD_X2, OPD_T);
            8'd7:   u = uw_op(UOP_M30, DST_V);
            8'd8:   u = uw_recip(OPD_V, DIV_42);
            8'd9:   u = uw_div(OPD_V, DST_T, DIV_42);
            8'd10:  u = uw_mul(OPD_X2, OPD_T);
            8'd11:  u = uw_op(UOP_M30, DST_V);
            8'd12:  u = uw_recip(OPD_V, DIV_20);
            8'd13:  u = uw_div(OPD_V, DST_T, DIV_20);
            8'd14:  u = uw_mul(OPD_X2, OPD_T);
            8'd15:  u = uw_op(UOP_M30, DST_V);
            8'd16:  u = uw_recip(OPD_V, DIV_6);
            8'd17:  u = uw_div(OPD_V, DST_T, DIV_6);
            8'd18:  u = uw_mul(OPD_X, OPD_T);
            8'd19:  u = uw_op(UOP_M30, DST_S);
            8'd20:  u = uw_recip(OPD_X2, DIV_90);
            8'd21:  u = uw_div(OPD_X2, DST_T, DIV_90);
            8'd22:  u = uw_mul(OPD_X2, OPD_T);
            8'd23:  u = uw_op(UOP_M30, DST_V);
            8'd24:  u = uw_recip(OPD_V, DIV_56);
            8'd25:  u = uw_div(OPD_V, DST_T, DIV_56);
            8'd26:  u = uw_mul(OPD_X2, OPD_T);
            8'd27:  u = uw_op(UOP_M30, DST_V);
            8'd28:  u = uw_recip(OPD_V, DIV_30);
            8'd29:  u = uw_div(OPD_V, DST_T, DIV_30);
            8'd30:  u = uw_mul(OPD_X2, OPD_T);
            8'd31:  u = uw_op(UOP_M30, DST_V);
            8'd32:  u = uw_recip(OPD_V, DIV_12);
            8'd33:  u = uw_div(OPD_V, DST_T, DIV_12);
            8'd34:  u = uw_mul(OPD_X2, OPD_T);
            8'd35:  u = uw_op(UOP_M30, DST_V);
            8'd36:  u = mk(UOP_HALF, OPD_V, OPD_X, DST_C, DIV_72);
            8'd37:  u = uw_op(UOP_QSIN, DST_SN);
            8'd38:  u = uw_op(UOP_QCOS, DST_CN);
            8'd39:  u = uw_op(UOP_LOOP, DST_NONE);
            // row 0
            8'd40:  u = uw_op(UOP_Q20, DST_J0);
            8'd41:  u = uw_mul(OPD_LC, OPD_CN2);
            8'd42:  u = uw_op(UOP_ASUB, DST_NONE);
            8'd43:  u = uw_mul(OPD_LT, OPD_CN1);
            8'd44:  u = uw_op(UOP_ASUB, DST_NONE);
            8'd45:  u = uw_op(UOP_Q20, DST_J1);
            8'd46:  u = uw_mul(OPD_LC, OPD_CN2);
            8'd47:  u = uw_op(UOP_ASUB, DST_NONE);
            8'd48:  u = uw_op(UOP_Q20, DST_J2);
            // row 1
            8'd49:  u = uw_mul(OPD_LH, OPD_SN0);
            8'd50:  u = uw_op(UOP_ACCL, DST_NONE);
            8'd51:  u = uw_mul(OPD_CN0, OPD_CN1);
            8'd52:  u = uw_op(UOP_M30, DST_V);
            8'd53:  u = uw_mul(OPD_LT, OPD_V);
            8'd54:  u = uw_op(UOP_AADD, DST_NONE);
            8'd55:  u = uw_mul(OPD_SN3, OPD_CN0);
            8'd56:  u = uw_op(UOP_M30, DST_V);
            8'd57:  u = uw_mul(OPD_V, OPD_SN1);
            8'd58:  u = uw_op(UOP_M30, DST_V);
            8'd59:  u = uw_mul(OPD_LC, OPD_V);
            8'd60:  u = uw_op(UOP_ASUB, DST_NONE);
            8'd61:  u = uw_mul(OPD_CN3, OPD_CN0);
            8'd62:  u = uw_op(UOP_M30, DST_V);
            8'd63:  u = uw_mul(OPD_V, OPD_CN1);
            8'd64:  u = uw_op(UOP_M30, DST_V);
            8'd65:  u = uw_mul(OPD_LC, OPD_V);
            8'd66:  u = uw_op(UOP_AADD, DST_NONE);
            8'd67:  u = uw_op(UOP_Q20, DST_J3);
            8'd68:  u = uw_mul(OPD_SN0, OPD_SN2);
            8'd69:  u = uw_op(UOP_M30, DST_V);
            8'd70:  u = uw_mul(OPD_LC, OPD_V);
            8'd71:  u = uw_op(UOP_ASUB, DST_NONE);
            8'd72:  u = uw_mul(OPD_SN0, OPD_SN1);
            8'd73:  u = uw_op(UOP_M30, DST_V);
            8'd74:  u = uw_mul(OPD_LT, OPD_V);
            8'd75:  u = uw_op(UOP_ASUB, DST_NONE);
            8'd76:  u = uw_op(UOP_Q20, DST_J4);
            8'd77:  u = uw_mul(OPD_SN2, OPD_SN0);
            8'd78:  u = uw_op(UOP_M30, DST_V);
            8'd79:  u = uw_mul(OPD_LC, OPD_V);
            8'd80:  u = uw_op(UOP_ASUB, DST_NONE);
            8'd81:  u = uw_op(UOP_Q20, DST_J5);
            // row 2
            8'd82:  u = uw_mul(OPD_LH, OPD_CN0);
            8'd83:  u = uw_op(UOP_ACCR, DST_NONE);
            8'd84:  u = uw_mul(OPD_CN1, OPD_SN0);
            8'd85:  u = uw_op(UOP_M30, DST_V);
            8'd86:  u = uw_mul(OPD_LT, OPD_V);
            8'd87:  u = uw_op(UOP_AADD, DST_NONE);
            8'd88:  u = uw_mul(OPD_CN3, OPD_CN1);
            8'd89:  u = uw_op(UOP_M30, DST_V);
            8'd90:  u = uw_mul(OPD_V, OPD_SN0);
            8'd91:  u = uw_op(UOP_M30, DST_V);
            8'd92:  u = uw_mul(OPD_LC, OPD_V);
            8'd93:  u = uw_op(UOP_AADD, DST_NONE);
            8'd94:  u = uw_mul(OPD_SN3, OPD_SN0);
            8'd95:  u = uw_op(UOP_M30, DST_V);
            8'd96:  u = uw_mul(OPD_V, OPD_SN1);
            8'd97:  u = uw_op(UOP_M30, DST_V);
            8'd98:  u = uw_mul(OPD_LC, OPD_V);
            8'd99:  u = uw_op(UOP_ASUB, DST_NONE);
            8'd100: u = uw_op(UOP_Q20, DST_J6);
            8'd101: u = uw_mul(OPD_CN0, OPD_SN2);
            8'd102: u = uw_op(UOP_M30, DST_V);
            8'd103: u = uw_mul(OPD_LC, OPD_V);
            8'd104: u = uw_op(UOP_AADD, DST_NONE);
            8'd105: u = uw_mul(OPD_CN0, OPD_SN1);
            8'd106: u = uw_op(UOP_M30, DST_V);
            8'd107: u = uw_mul(OPD_LT, OPD_V);
            8'd108: u = uw_op(UOP_AADD, DST_NONE);
            8'd109: u = uw_op(UOP_Q20, DST_J7);
            8'd110: u = uw_mul(OPD_SN2, OPD_CN0);
            8'd111: u = uw_op(UOP_M30, DST_V);
            8'd112: u = uw_mul(OPD_LC, OPD_V);
            8'd113: u = uw_op(UOP_AADD, DST_NONE);
            8'd114: u = uw_op(UOP_Q20, DST_J8);
            8'd115: u = uw_op(UOP_END, DST_NONE);
            // torques: transpose of J times force
            8'd116: u = uw_mul(OPD_J0, OPD_FX);
            8'd117: u = uw_op(UOP_AADD, DST_NONE);
            8'd118: u = uw_mul(OPD_J3, OPD_FY);
            8'd119: u = uw_op(UOP_AADD, DST_NONE);
            8'd120: u = uw_mul(OPD_J6, OPD_FZ);
            8'd121: u = uw_op(UOP_AADD, DST_NONE);
            8'd122: u = uw_op(UOP_TRQ, DST_TQ0);
            8'd123: u = uw_mul(OPD_J1, OPD_FX);
            8'd124: u = uw_op(UOP_AADD, DST_NONE);
            8'd125: u = uw_mul(OPD_J4, OPD_FY);
            8'd126: u = uw_op(UOP_AADD, DST_NONE);
            8'd127: u = uw_mul(OPD_J7, OPD_FZ);
            8'd128: u = uw_op(UOP_AADD, DST_NONE);
            8'd129: u = uw_op(UOP_TRQ, DST_TQ1);
            8'd130: u = uw_mul(OPD_J2, OPD_FX);
            8'd131: u = uw_op(UOP_AADD, DST_NONE);
            8'd132: u = uw_mul(OPD_J5, OPD_FY);
            8'd133: u = uw_op(UOP_AADD, DST_NONE);
            8'd134: u = uw_mul(OPD_J8, OPD_FZ);
            8'd135: u = uw_op(UOP_AADD, DST_NONE);
            8'd136: u = uw_op(UOP_TRQ, DST_TQ2);
            default: u = uw_op(UOP_END, DST_NONE);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// ===== sv/leg_jacobian_and_joint_torque.sv =====
// Top level of the leg Jacobian and joint torque block.
//
//  channel  dir  handshake           payload
//  s        in   s_tvalid/s_tready   s_tdata, s_tuser (op)
//  m        out  m_tvalid/m_tready   m_tdata, m_tuser (kind), m_tlast
//  cfg      in   cfg_we              cfg_index, cfg_data
//
// An angles word runs four trig passes of 40 steps, one extra step per quadrant reduction
// (up to 8 on a pass, 19 over all four passes), then 76 Jacobian steps; three row words
// follow. A force word runs the torque steps, then one torque word. All products come
// from the single shared 32x32 multiplier, stepped by the microprogram sequencer. One word
// is in work at a time; input is taken again the cycle
// after the last result word leaves, so a stalled receiver stalls the input.
// The Jacobian store resets to zero.
`default_nettype none
module leg_jacobian_and_joint_torque
    import ljjt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // hip angle, thigh angle, knee angle, force_x, force_y, force_z
    input  wire logic [119:0] s_tdata,
    // op
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // row_index, value_a, value_b, value_c, zero pad
    output logic [103:0]      m_tdata,
    // kind
    output logic              m_tuser,
    output logic              m_tlast,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    ljjt_cmd_t  cmd;
    ljjt_stat_t stat;

    ljjt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .stat     (stat),
        .cmd      (cmd)
    );

    ljjt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata)
    );

    assign m_tuser = cmd.kind;

endmodule
`default_nettype wire

// ===== sv/ljjt_ctrl.sv =====
// Sequencer: handshakes, microprogram counter and result word control.
`default_nettype none
module ljjt_ctrl
    import ljjt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic       s_tuser,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic            m_tlast,
    input  wire ljjt_stat_t stat,
    output ljjt_cmd_t       cmd
);

    ljjt_state_t state_reg, state_next;
    logic [7:0]  pc_reg, pc_next;
    logic [1:0]  ti_reg, ti_next;
    logic [1:0]  row_reg, row_next;
    logic        kind_reg, kind_next;
    uword_t      uw;
    logic        s_acc;
    logic        m_acc;
    logic        last_word;

    assign uw        = ucode(pc_reg);
    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;
    assign last_word = (kind_reg == KIND_TORQUE) || (row_reg == 2'd2);

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        ti_next    = ti_reg;
        row_next   = row_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next  = s_tuser;
                    pc_next    = (s_tuser == OP_FORCE) ? PC_FORCE : PC_TRIG;
                    ti_next    = 2'd0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                priority case (uw.op)
                    UOP_RED:
                    begin
                        if (stat.reduced)
                            pc_next = pc_reg + 8'd1;
                    end
                    UOP_LOOP:
                    begin
                        if (ti_reg == 2'd3)
                            pc_next = pc_reg + 8'd1;
                        else
                        begin
                            ti_next = ti_reg + 2'd1;
                            pc_next = PC_TRIG;
                        end
                    end
                    UOP_END:
                    begin
                        row_next   = 2'd0;
                        state_next = ST_EMIT;
                    end
                    default: pc_next = pc_reg + 8'd1;
                endcase
            end
            ST_EMIT:
            begin
                if (m_acc)
                begin
                    if (last_word)
                    begin
                        row_next   = 2'd0;
                        state_next = ST_IDLE;
                    end
                    else
                        row_next = row_reg + 2'd1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_EMIT);
        m_tlast  = last_word;
        cmd.run  = (state_reg == ST_RUN);
        cmd.load = s_acc;
        cmd.uw   = uw;
        cmd.ti   = ti_reg;
        cmd.row  = row_reg;
        cmd.kind = kind_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= PC_TRIG;
            ti_reg    <= 2'd0;
            row_reg   <= 2'd0;
            kind_reg  <= KIND_ROW;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            ti_reg    <= ti_next;
            row_reg   <= row_next;
            kind_reg  <= kind_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/ljjt_dp.sv =====
// Datapath: configuration, shared multiplier, accumulator, trig and Jacobian registers.
`default_nettype none
module ljjt_dp
    import ljjt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [119:0] s_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    input  wire ljjt_cmd_t    cmd,
    output ljjt_stat_t        stat,
    output logic [103:0]      m_tdata
);

    logic [15:0]        hip_len_reg, thigh_len_reg, calf_len_reg;
    logic signed [15:0] offset_reg;
    logic               side_reg;

    logic signed [15:0] ang_h_reg, ang_t_reg, ang_c_reg;
    logic signed [23:0] fx_reg, fy_reg, fz_reg;

    logic signed [NW-1:0] n_reg;
    logic [1:0]           k_reg;
    logic signed [31:0]   x_reg, x2_reg, t_reg, v_reg, s_reg, c_reg;
    logic signed [31:0]   sn_reg [4];
    logic signed [31:0]   cn_reg [4];
    logic signed [31:0]   j_reg  [9];
    logic signed [31:0]   tq_reg [3];
    logic signed [63:0]   p_reg;
    logic signed [63:0]   acc_reg, acc_next;

    logic signed [31:0]   a_val, b_val, res;
    logic signed [63:0]   prod;
    logic signed [63:0]   m30_w, q20_w, trq_w;
    logic signed [17:0]   ang_sum;
    logic signed [NW-1:0] n_load;
    logic [31:0]          q0;
    logic [38:0]          qd;
    logic signed [39:0]   rem;
    logic [31:0]          quot;
    logic [6:0]           dval;
    logic                 run;

    assign run = cmd.run;

    function automatic logic signed [31:0] pick(input opd_t sel,
        input logic signed [31:0] x, input logic signed [31:0] x2,
        input logic signed [31:0] t, input logic signed [31:0] v,
        input logic [31:0] rc);
        logic signed [31:0] r;
        r = x;
        unique case (sel)
            OPD_X:     r = x;
            OPD_X2:    r = x2;
            OPD_T:     r = t;
            OPD_V:     r = v;
            OPD_RECIP: r = $signed(rc);
            default:   r = x;
        endcase
        return r;
    endfunction

    // operand selection
    always_comb
    begin
        dval  = div_value(cmd.uw.dv);
        a_val = pick(cmd.uw.a, x_reg, x2_reg, t_reg, v_reg, div_recip(cmd.uw.dv));
        b_val = pick(cmd.uw.b, x_reg, x2_reg, t_reg, v_reg, div_recip(cmd.uw.dv));
        unique case (cmd.uw.a)
            OPD_LH:  a_val = $signed({16'd0, hip_len_reg});
            OPD_LT:  a_val = $signed({16'd0, thigh_len_reg});
            OPD_LC:  a_val = $signed({16'd0, calf_len_reg});
            OPD_SN0: a_val = sn_reg[0];
            OPD_SN1: a_val = sn_reg[1];
            OPD_SN2: a_val = sn_reg[2];
            OPD_SN3: a_val = sn_reg[3];
            OPD_CN0: a_val = cn_reg[0];
            OPD_CN1: a_val = cn_reg[1];
            OPD_CN2: a_val = cn_reg[2];
            OPD_CN3: a_val = cn_reg[3];
            OPD_J0:  a_val = j_reg[0];
            OPD_J1:  a_val = j_reg[1];
            OPD_J2:  a_val = j_reg[2];
            OPD_J3:  a_val = j_reg[3];
            OPD_J4:  a_val = j_reg[4];
            OPD_J5:  a_val = j_reg[5];
            OPD_J6:  a_val = j_reg[6];
            OPD_J7:  a_val = j_reg[7];
            OPD_J8:  a_val = j_reg[8];
            default: ;
        endcase
        unique case (cmd.uw.b)
            OPD_SN0: b_val = sn_reg[0];
            OPD_SN1: b_val = sn_reg[1];
            OPD_SN2: b_val = sn_reg[2];
            OPD_SN3: b_val = sn_reg[3];
            OPD_CN0: b_val = cn_reg[0];
            OPD_CN1: b_val = cn_reg[1];
            OPD_CN2: b_val = cn_reg[2];
            OPD_CN3: b_val = cn_reg[3];
            OPD_FX:  b_val = 32'(fx_reg);
            OPD_FY:  b_val = 32'(fy_reg);
            OPD_FZ:  b_val = 32'(fz_reg);
            default: ;
        endcase
    end

    assign prod = a_val * b_val;

    // angle of the current pass, shifted to Q.30 and offset by an eighth turn
    always_comb
    begin
        unique case (cmd.ti)
            2'd0:    ang_sum = 18'(ang_h_reg);
            2'd1:    ang_sum = 18'(ang_t_reg);
            2'd2:    ang_sum = 18'(ang_c_reg) + 18'(ang_t_reg) + 18'(offset_reg);
            default: ang_sum = 18'(ang_c_reg) + 18'(offset_reg);
        endcase
        n_load = (NW'(ang_sum) <<< 17) + QTR_PI_Q30;
    end

    assign stat.reduced = (n_reg >= 0) && (n_reg < HALF_PI_Q30);

    // result of the current micro-op
    always_comb
    begin
        m30_w = p_reg + 64'sd536870912;
        q20_w = acc_reg + 64'sd33554432;
        trq_w = (acc_reg + 64'sd524288) >>> 20;
        q0    = p_reg[63:32];
        qd    = 39'(q0) * 39'(dval);
        rem   = 40'(a_val) - $signed({1'b0, qd});
        quot  = (rem >= $signed({33'd0, dval})) ? q0 + 32'd1 : q0;
        res   = m30_w[61:30];
        unique case (cmd.uw.op)
            UOP_M30:  res = m30_w[61:30];
            UOP_DIVF: res = Q30_ONE - $signed(quot);
            UOP_HALF: res = Q30_ONE - (a_val >>> 1);
            UOP_QSIN:
            begin
                unique case (k_reg)
                    2'd0:    res = s_reg;
                    2'd1:    res = c_reg;
                    2'd2:    res = -s_reg;
                    default: res = -c_reg;
                endcase
            end
            UOP_QCOS:
            begin
                unique case (k_reg)
                    2'd0:    res = c_reg;
                    2'd1:    res = -s_reg;
                    2'd2:    res = -c_reg;
                    default: res = s_reg;
                endcase
            end
            UOP_Q20:  res = q20_w[57:26];
            UOP_TRQ:
            begin
                if (trq_w > 64'sd2147483647)
                    res = 32'sh7fffffff;
                else if (trq_w < -64'sd2147483648)
                    res = 32'sh80000000;
                else
                    res = trq_w[31:0];
            end
            default: ;
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (run)
        begin
            unique case (cmd.uw.op)
                UOP_AADD: acc_next = acc_reg + p_reg;
                UOP_ASUB: acc_next = acc_reg - p_reg;
                UOP_ACCL: acc_next = side_reg ? acc_reg + p_reg : acc_reg - p_reg;
                UOP_ACCR: acc_next = side_reg ? acc_reg - p_reg : acc_reg + p_reg;
                UOP_Q20,
                UOP_TRQ:  acc_next = '0;
                default: ;
            endcase
        end
    end

    // configuration, accumulator and Jacobian store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hip_len_reg   <= '0;
            thigh_len_reg <= '0;
            calf_len_reg  <= '0;
            offset_reg    <= '0;
            side_reg      <= 1'b0;
            acc_reg       <= '0;
            for (int i = 0; i < 9; i++)
                j_reg[i] <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_HIP_LENGTH:   hip_len_reg   <= cfg_data;
                    CFG_THIGH_LENGTH: thigh_len_reg <= cfg_data;
                    CFG_CALF_LENGTH:  calf_len_reg  <= cfg_data;
                    CFG_CALF_OFFSET:  offset_reg    <= $signed(cfg_data);
                    CFG_LEG_SIDE:     side_reg      <= cfg_data[0];
                    default: ;
                endcase
            end
            if (run)
            begin
                unique case (cmd.uw.dst)
                    DST_J0:  j_reg[0] <= res;
                    DST_J1:  j_reg[1] <= res;
                    DST_J2:  j_reg[2] <= res;
                    DST_J3:  j_reg[3] <= res;
                    DST_J4:  j_reg[4] <= res;
                    DST_J5:  j_reg[5] <= res;
                    DST_J6:  j_reg[6] <= res;
                    DST_J7:  j_reg[7] <= res;
                    DST_J8:  j_reg[8] <= res;
                    default: ;
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ang_h_reg <= $signed(s_tdata[15:0]);
            ang_t_reg <= $signed(s_tdata[31:16]);
            ang_c_reg <= $signed(s_tdata[47:32]);
            fx_reg    <= $signed(s_tdata[71:48]);
            fy_reg    <= $signed(s_tdata[95:72]);
            fz_reg    <= $signed(s_tdata[119:96]);
        end
        if (run)
        begin
            if (cmd.uw.op == UOP_MUL)
                p_reg <= prod;
            if (cmd.uw.op == UOP_ANG)
            begin
                n_reg <= n_load;
                k_reg <= 2'd0;
            end
            if (cmd.uw.op == UOP_RED)
            begin
                if (n_reg >= HALF_PI_Q30)
                begin
                    n_reg <= n_reg - HALF_PI_Q30;
                    k_reg <= k_reg + 2'd1;
                end
                else if (n_reg < 0)
                begin
                    n_reg <= n_reg + HALF_PI_Q30;
                    k_reg <= k_reg - 2'd1;
                end
                else
                    x_reg <= 32'(n_reg - QTR_PI_Q30);
            end
            unique case (cmd.uw.dst)
                DST_X2:  x2_reg <= res;
                DST_T:   t_reg  <= res;
                DST_V:   v_reg  <= res;
                DST_S:   s_reg  <= res;
                DST_C:   c_reg  <= res;
                DST_SN:  sn_reg[cmd.ti] <= res;
                DST_CN:  cn_reg[cmd.ti] <= res;
                DST_TQ0: tq_reg[0] <= res;
                DST_TQ1: tq_reg[1] <= res;
                DST_TQ2: tq_reg[2] <= res;
                default: ;
            endcase
        end
    end

    // result word
    always_comb
    begin
        logic signed [31:0] va, vb, vc;
        if (cmd.kind == KIND_TORQUE)
        begin
            va = tq_reg[0];
            vb = tq_reg[1];
            vc = tq_reg[2];
        end
        else
        begin
            unique case (cmd.row)
                2'd0:
                begin
                    va = j_reg[0];
                    vb = j_reg[1];
                    vc = j_reg[2];
                end
                2'd1:
                begin
                    va = j_reg[3];
                    vb = j_reg[4];
                    vc = j_reg[5];
                end
                default:
                begin
                    va = j_reg[6];
                    vb = j_reg[7];
                    vc = j_reg[8];
                end
            endcase
        end
        m_tdata = {6'd0, vc, vb, va, (cmd.kind == KIND_TORQUE) ? 2'd0 : cmd.row};
    end

endmodule
`default_nettype wire

// ===== sv/ljjt_checker.sv =====
// Port-level checks of the leg Jacobian and torque block, bound to the top level.
`default_nettype none
module ljjt_checker
    import ljjt_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata,
    input wire logic         m_tuser,
    input wire logic         m_tlast
);

    // hold a stalled result word
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken before the first finished");

    a_torque_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_TORQUE) |-> m_tlast && (m_tdata[1:0] == 2'd0))
        else $error("torque word must be a lone row 0 word");

    a_row_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ROW) |-> (m_tlast == (m_tdata[1:0] == 2'd2)))
        else $error("last flag does not match row number");

endmodule

bind leg_jacobian_and_joint_torque ljjt_checker u_ljjt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== tb/leg_jacobian_and_joint_torque_test.sv =====
// Self-checking testbench: leg Jacobian and joint torque block against a bit-exact predictor.
`default_nettype none
module leg_jacobian_and_joint_torque_test;
    import ljjt_pkg::*;

    localparam longint QUARTER_TURN = 64'sd1686629713;  // pi/2 in Q.30
    localparam longint UNIT_Q30     = 64'sd1073741824;

    typedef struct {
        logic               op;
        logic signed [15:0] hip;
        logic signed [15:0] thigh;
        logic signed [15:0] calf;
        logic signed [23:0] fx;
        logic signed [23:0] fy;
        logic signed [23:0] fz;
    } leg_word_t;

    typedef struct {
        logic               kind;
        logic [1:0]         row;
        logic signed [31:0] va;
        logic signed [31:0] vb;
        logic signed [31:0] vc;
        logic               last;
    } leg_result_t;

    // directed word plus a flag for an all-zero result typed in by hand
    typedef struct {
        leg_word_t w;
        logic      all_zero;
    } directed_row_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [119:0]       s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [103:0]       m_tdata;
    logic               m_tuser;
    logic               m_tlast;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;

    // predictor copy of the registers and the stored Jacobian
    logic [15:0]        link_hip;
    logic [15:0]        link_thigh;
    logic [15:0]        link_shin;
    logic signed [15:0] knee_zero;
    logic               right_leg;
    logic signed [31:0] jac[9];

    leg_result_t        pending_results[$];
    int                 errors;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 hold_left;

    leg_jacobian_and_joint_torque u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic longint round_down(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        return round_down(a * b, 30);
    endfunction

    function automatic void sin_cos(input longint ang, output longint sn, output longint cs);
        longint n, k, x, x2, t, s, c;
        n = ang + QUARTER_TURN / 2;
        if (n >= 0)
            k = n / QUARTER_TURN;
        else
            k = -((-n + QUARTER_TURN - 1) / QUARTER_TURN);
        x  = ang - k * QUARTER_TURN;
        x2 = mul_q30(x, x);
        t = UNIT_Q30 - x2 / 72;
        t = UNIT_Q30 - mul_q30(x2, t) / 42;
        t = UNIT_Q30 - mul_q30(x2, t) / 20;
        t = UNIT_Q30 - mul_q30(x2, t) / 6;
        s = mul_q30(x, t);
        t = UNIT_Q30 - x2 / 90;
        t = UNIT_Q30 - mul_q30(x2, t) / 56;
        t = UNIT_Q30 - mul_q30(x2, t) / 30;
        t = UNIT_Q30 - mul_q30(x2, t) / 12;
        c = UNIT_Q30 - mul_q30(x2, t) / 2;
        case (k[1:0])
            2'd0: begin sn = s;  cs = c;  end
            2'd1: begin sn = c;  cs = -s; end
            2'd2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endfunction

    function automatic logic signed [31:0] to_q20(input longint v);
        longint r;
        r = round_down(v, 26);
        return r[31:0];
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic void update_jacobian(input leg_word_t w);
        longint lh, lt, lc, off, qh, qt, qc;
        longint s1, c1, s2, c2, s23, c23, s3o, c3o, h10, h20;
        lh  = longint'(link_hip);
        lt  = longint'(link_thigh);
        lc  = longint'(link_shin);
        off = longint'(knee_zero);
        qh  = longint'(w.hip);
        qt  = longint'(w.thigh);
        qc  = longint'(w.calf);
        sin_cos(qh * 131072, s1, c1);
        sin_cos(qt * 131072, s2, c2);
        sin_cos((qc + qt + off) * 131072, s23, c23);
        sin_cos((qc + off) * 131072, s3o, c3o);
        h10 = lh * s1;
        h20 = lh * c1;
        // hip offset flips with the side of the body
        if (!right_leg)
            h10 = -h10;
        else
            h20 = -h20;
        jac[0] = '0;
        jac[1] = to_q20(-lc * c23 - lt * c2);
        jac[2] = to_q20(-lc * c23);
        jac[3] = to_q20(h10 + lt * mul_q30(c1, c2) - lc * mul_q30(mul_q30(s3o, c1), s2)
                        + lc * mul_q30(mul_q30(c3o, c1), c2));
        jac[4] = to_q20(-(lc * mul_q30(s1, s23) + lt * mul_q30(s1, s2)));
        jac[5] = to_q20(-lc * mul_q30(s23, s1));
        jac[6] = to_q20(h20 + lt * mul_q30(c2, s1) + lc * mul_q30(mul_q30(c3o, c2), s1)
                        - lc * mul_q30(mul_q30(s3o, s1), s2));
        jac[7] = to_q20(lc * mul_q30(c1, s23) + lt * mul_q30(c1, s2));
        jac[8] = to_q20(lc * mul_q30(s23, c1));
    endfunction

    function automatic void predict_leg(input leg_word_t w, input logic all_zero);
        leg_result_t r;
        longint      f[3];
        longint      acc;
        logic signed [31:0] tq[3];
        if (w.op == OP_ANGLES)
        begin
            update_jacobian(w);
            for (int i = 0; i < 3; i++)
            begin
                r.kind = KIND_ROW;
                r.row  = 2'(i);
                r.va   = all_zero ? 32'sd0 : jac[i*3];
                r.vb   = all_zero ? 32'sd0 : jac[i*3+1];
                r.vc   = all_zero ? 32'sd0 : jac[i*3+2];
                r.last = (i == 2);
                pending_results.push_back(r);
            end
        end
        else
        begin
            f[0] = longint'(w.fx);
            f[1] = longint'(w.fy);
            f[2] = longint'(w.fz);
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int i = 0; i < 3; i++)
                    acc += longint'(jac[i*3+j]) * f[i];
                tq[j] = all_zero ? 32'sd0 : clamp32(round_down(acc, 20));
            end
            r.kind = KIND_TORQUE;
            r.row  = 2'd0;
            r.va   = tq[0];
            r.vb   = tq[1];
            r.vc   = tq[2];
            r.last = 1'b1;
            pending_results.push_back(r);
        end
    endfunction

    // ---------------- drivers ----------------
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_HIP_LENGTH:   link_hip   = val;
            CFG_THIGH_LENGTH: link_thigh = val;
            CFG_CALF_LENGTH:  link_shin  = val;
            CFG_CALF_OFFSET:  knee_zero  = val;
            CFG_LEG_SIDE:     right_leg  = val[0];
            default: ;
        endcase
    endtask

    task automatic set_leg(input logic [15:0] lh, input logic [15:0] lt, input logic [15:0] lc,
                           input logic [15:0] off, input logic side);
        write_reg(CFG_HIP_LENGTH, lh);
        write_reg(CFG_THIGH_LENGTH, lt);
        write_reg(CFG_CALF_LENGTH, lc);
        write_reg(CFG_CALF_OFFSET, off);
        write_reg(CFG_LEG_SIDE, {15'($urandom), side});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_word(input leg_word_t w, input logic all_zero);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.op;
        s_tdata  <= {w.fz, w.fy, w.fx, w.calf, w.thigh, w.hip};
        do
            @(posedge clk);
        while (!s_tready);
        predict_leg(w, all_zero);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic leg_word_t random_word(input int angle_pct);
        leg_word_t w;
        w.op    = ($urandom_range(99) < angle_pct) ? OP_ANGLES : OP_FORCE;
        w.hip   = 16'($urandom);
        w.thigh = 16'($urandom);
        w.calf  = 16'($urandom);
        w.fx    = 24'($urandom);
        w.fy    = 24'($urandom);
        w.fz    = 24'($urandom);
        // mostly moderate joint angles, a few at full range; forces mostly at full range, a few moderate
        if ($urandom_range(3) != 0)
        begin
            w.hip   = 16'($signed($urandom_range(25736)) - 12868);
            w.thigh = 16'($signed($urandom_range(25736)) - 12868);
            w.calf  = 16'($signed($urandom_range(25736)) - 12868);
        end
        if ($urandom_range(3) == 0)
        begin
            w.fx = 24'($signed($urandom_range(51200)) - 25600);
            w.fy = 24'($signed($urandom_range(51200)) - 25600);
            w.fz = 24'($signed($urandom_range(51200)) - 25600);
        end
        return w;
    endfunction

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++)
            send_word(random_word(50), 1'b0);
        drain();
    endtask

    // ---------------- receiver and result check ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        leg_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected word tdata=%h tuser=%b tlast=%b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (m_tuser !== exp_r.kind)
                begin
                    $display("%0t: kind exp %b got %b", $time, exp_r.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[1:0] !== exp_r.row)
                begin
                    $display("%0t: row exp %0d got %0d", $time, exp_r.row, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[33:2] !== exp_r.va)
                begin
                    $display("%0t: value_a exp %h got %h", $time, exp_r.va, m_tdata[33:2]);
                    errors++;
                end
                if (m_tdata[65:34] !== exp_r.vb)
                begin
                    $display("%0t: value_b exp %h got %h", $time, exp_r.vb, m_tdata[65:34]);
                    errors++;
                end
                if (m_tdata[97:66] !== exp_r.vc)
                begin
                    $display("%0t: value_c exp %h got %h", $time, exp_r.vc, m_tdata[97:66]);
                    errors++;
                end
                if (m_tdata[103:98] !== 6'd0)
                begin
                    $display("%0t: pad exp 0 got %h", $time, m_tdata[103:98]);
                    errors++;
                end
                if (m_tlast !== exp_r.last)
                begin
                    $display("%0t: last exp %b got %b", $time, exp_r.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // ---------------- sequence ----------------
    directed_row_t directed[$];

    function automatic directed_row_t drow(input logic op,
                                          input int h, input int t, input int c,
                                          input int x, input int y, input int z,
                                          input logic zero);
        directed_row_t d;
        d.w.op    = op;
        d.w.hip   = 16'(h);
        d.w.thigh = 16'(t);
        d.w.calf  = 16'(c);
        d.w.fx    = 24'(x);
        d.w.fy    = 24'(y);
        d.w.fz    = 24'(z);
        d.all_zero = zero;
        return d;
    endfunction

    initial
    begin
        errors         = 0;
        hold_left      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        link_hip       = '0;
        link_thigh     = '0;
        link_shin      = '0;
        knee_zero      = '0;
        right_leg      = 1'b0;
        foreach (jac[i])
            jac[i] = '0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state: zero store and zero lengths give all-zero words
        directed.push_back(drow(OP_FORCE, 32767, -32768, 123, 8388607, -8388608, 8388607, 1));
        directed.push_back(drow(OP_ANGLES, -32768, 32767, 0, 8388607, 8388607, -8388608, 1));
        directed.push_back(drow(OP_FORCE, -1, -1, -1, -8388608, -8388608, -8388608, 1));
        foreach (directed[i])
            send_word(directed[i].w, directed[i].all_zero);
        drain();

        // longest links, left leg; then extreme angles and forces
        directed.delete();
        set_leg(16'hffff, 16'hffff, 16'hffff, 16'h0000, 1'b0);
        write_reg(3'd5, 16'h1234);   // indexes past the list are ignored
        write_reg(3'd6, 16'hffff);
        write_reg(3'd7, 16'h0001);
        cfg_we <= 1'b0;
        directed.push_back(drow(OP_ANGLES, 0, 0, 0, -1, -1, -1, 0));
        directed.push_back(drow(OP_FORCE, 0, 0, 0, 256, 256, 256, 0));
        directed.push_back(drow(OP_ANGLES, 32767, 32767, 32767, 0, 0, 0, 0));
        directed.push_back(drow(OP_FORCE, 0, 0, 0, 8388607, 8388607, 8388607, 0));
        directed.push_back(drow(OP_ANGLES, -32768, -32768, -32768, 0, 0, 0, 0));
        directed.push_back(drow(OP_FORCE, 0, 0, 0, -8388608, -8388608, -8388608, 0));
        directed.push_back(drow(OP_FORCE, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(drow(OP_ANGLES, 12868, -6434, 25736, 0, 0, 0, 0));
        directed.push_back(drow(OP_FORCE, 0, 0, 0, 8388607, -8388608, 8388607, 0));
        foreach (directed[i])
            send_word(directed[i].w, directed[i].all_zero);
        drain();

        // right leg, then left leg; extreme calf offsets
        directed.delete();
        set_leg(16'h8000, 16'h4000, 16'hffff, 16'h7fff, 1'b1);
        directed.push_back(drow(OP_ANGLES, 4000, -9000, 14000, 0, 0, 0, 0));
        directed.push_back(drow(OP_FORCE, 0, 0, 0, 25600, -12800, 51200, 0));
        directed.push_back(drow(OP_ANGLES, 32767, -32768, 32767, 0, 0, 0, 0));
        foreach (directed[i])
            send_word(directed[i].w, directed[i].all_zero);
        drain();
        directed.delete();
        set_leg(16'h1000, 16'h6000, 16'h5800, 16'h8000, 1'b0);
        directed.push_back(drow(OP_ANGLES, -7000, 11000, -20000, 0, 0, 0, 0));
        directed.push_back(drow(OP_FORCE, 0, 0, 0, -8388608, 8388607, -8388608, 0));
        foreach (directed[i])
            send_word(directed[i].w, directed[i].all_zero);
        drain();

        random_run(90);

        set_leg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        send_idle_pct = 56;
        random_run(90);

        set_leg(16'($urandom_range(16384)), 16'($urandom_range(30000)),
                16'($urandom_range(30000)), 16'($signed($urandom_range(8000)) - 4000), 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 56;
        random_run(90);

        set_leg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        random_run(90);

        // long receiver hold-off while words keep coming; input must stall
        set_leg(16'hffff, 16'h0000, 16'hffff, 16'h8000, 1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 3000;
        random_run(20);

        set_leg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
        recv_stall_pct = 10;
        random_run(80);

        if (errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/ljjt_pkg.sv
sv/ljjt_ctrl.sv
sv/ljjt_dp.sv
sv/leg_jacobian_and_joint_torque.sv
sv/ljjt_checker.sv
tb/leg_jacobian_and_joint_torque_test.sv
